/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cvd_pkg.sv */
// Types, constants and codes shared by the velocity drive model modules.
package cvd_pkg;

    // Fixed-point fraction bits of velocity and position.
    localparam int FRAC_BITS = 16;

    localparam int NODE_W = 7;
    localparam int MAXV_W = 31;
    localparam int DT_W   = 16;

    // Datapath widths; all but POS_W are derived from FRAC_BITS.
    localparam int VEL_W  = FRAC_BITS + 32;   // actual velocity, signed
    localparam int ERR_W  = FRAC_BITS + 33;   // target - actual, signed
    localparam int E5_W   = FRAC_BITS + 36;   // 5 * error, signed
    localparam int MAG_W  = FRAC_BITS + 35;   // magnitude fed to the multiplier
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = HI_W + DT_W;
    localparam int SUM_W  = FRAC_BITS + 37;   // velocity before clamping
    localparam int POS_W  = 64;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL = 2'd1;

    localparam logic [NODE_W-1:0] NODE_ID_RST = 7'd2;
    localparam logic [MAXV_W-1:0] MAX_VEL_RST = 31'd10000;

    // Input word opcodes.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Protocol constants.
    localparam logic [3:0]  FC_RPDO        = 4'h4;
    localparam logic [3:0]  ENABLE_MASK    = 4'hF;
    localparam logic [3:0]  DLC_CTRL_MIN   = 4'd2;
    localparam logic [3:0]  DLC_TARGET_MIN = 4'd6;
    localparam logic [15:0] STATUS_ON      = 16'h1637;
    localparam logic [15:0] STATUS_OFF     = 16'h0650;
    localparam logic [10:0] TPDO_BASE      = 11'h180;
    localparam logic [3:0]  TPDO_FC        = 4'h3;

    typedef struct packed {
        logic        op;
        logic [10:0] can_id;
        logic [3:0]  dlc;
        logic [47:0] payload;
        logic [15:0] tick_time;
    } rx_word_t;

    typedef struct packed {
        logic [10:0]        tx_id;
        logic [15:0]        drive_status;
        logic signed [31:0] velocity_out;
        logic signed [15:0] position_out;
    } tx_word_t;

    typedef enum logic [0:0] {
        CMD_CTRL,
        CMD_TICK
    } cmd_kind_t;

    // Classified command handed from front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic               enable;
        logic               set_target;
        logic signed [31:0] target;
        logic [DT_W-1:0]    dt;
    } cmd_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

/* src/canopen_velocity_drive_model_unit.sv */
// A control frame is registered in the command queue and applied when the back end pops it;
// a disabled tick goes straight to ST_EMIT for its status word, an enabled one first runs the update.
// The back end pops a new command only from ST_IDLE, so an enabled tick first finishes two passes through the single
// shared 26x16 multiplier and the error, clamp and accumulate steps around it.
// A two-entry command queue lets input words be accepted while a status word waits.
// Reset: drive disabled, target, velocity and position zero, node 2, limit 10000 mrad/s.
module canopen_velocity_drive_model_unit
    import cvd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  rx_word_t             rx_word,
    output logic                 tx_valid,
    input  logic                 tx_stall,
    output tx_word_t             tx_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAXV_W-1:0]    cfg_data
);

    logic [NODE_W-1:0] node_id_reg;
    logic [MAXV_W-1:0] max_vel_reg;
    q_stat_t           q_stat;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    cmd_t              head_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= NODE_ID_RST;
            max_vel_reg <= MAX_VEL_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_NODE_ID)
            begin
                node_id_reg <= cfg_data[NODE_W-1:0];
            end
            else if (cfg_index == REG_MAX_VEL)
            begin
                max_vel_reg <= cfg_data;
            end
        end
    end

    cvd_front u_front (
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_word  (rx_word),
        .node_id  (node_id_reg),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cvd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_stat   (q_stat),
        .head_cmd (head_cmd)
    );

    cvd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_stat.valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .node_id     (node_id_reg),
        .speed_limit (max_vel_reg),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .tx_word     (tx_word)
    );

endmodule

/* src/cvd_front.sv */
// Front end: accepts input words, drops foreign frames, and queues commands.
module cvd_front
    import cvd_pkg::*;
(
    input  logic              rx_valid,
    output logic              rx_stall,
    input  rx_word_t          rx_word,
    input  logic [NODE_W-1:0] node_id,
    input  q_stat_t           q_stat,
    output logic              push,
    output cmd_t              push_cmd
);

    logic frame_hit;

    // Match node, function code and minimum length of a control frame.
    assign frame_hit = (rx_word.op == OP_FRAME)
                    && (rx_word.can_id[6:0] == node_id)
                    && (rx_word.can_id[10:7] == FC_RPDO)
                    && (rx_word.dlc >= DLC_CTRL_MIN);

    // Hold the input while the queue is full.
    assign rx_stall = q_stat.full;

    // Queue ticks and matching frames; drop the rest.
    assign push = rx_valid && !q_stat.full && ((rx_word.op == OP_TICK) || frame_hit);

    // Build the command word.
    always_comb
    begin
        push_cmd.kind       = (rx_word.op == OP_TICK) ? CMD_TICK : CMD_CTRL;
        push_cmd.enable     = (rx_word.payload[3:0] == ENABLE_MASK);
        push_cmd.set_target = (rx_word.dlc >= DLC_TARGET_MIN);
        push_cmd.target     = $signed(rx_word.payload[47:16]);
        push_cmd.dt         = rx_word.tick_time;
    end

endmodule

/* src/cvd_queue.sv */
// Short command queue decoupling the front end from the back end.
module cvd_queue
    import cvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output q_stat_t q_stat,
    output cmd_t    head_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.valid;

    // Advance pointers and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/cvd_back.sv */
// Back end: applies control commands and runs the velocity and position update.
module cvd_back
    import cvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              head_cmd,
    output logic              pop,
    input  logic [NODE_W-1:0] node_id,
    input  logic [MAXV_W-1:0] speed_limit,
    output logic              tx_valid,
    input  logic              tx_stall,
    output tx_word_t          tx_word
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_ERR5,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_SUM_V,
        ST_CLAMP,
        ST_POS_MAG,
        ST_SUM_P,
        ST_EMIT
    } state_t;

    state_t                    state_reg,   state_next;
    logic                      enabled_reg, enabled_next;
    logic signed [31:0]        target_reg,  target_next;
    logic signed [VEL_W-1:0]   actual_reg,  actual_next;
    logic [POS_W-1:0]          shaft_reg,   shaft_next;
    logic                      tx_valid_reg, tx_valid_next;
    tx_word_t                  tx_word_reg, tx_word_next;

    logic [DT_W-1:0]           dt_reg,      dt_next;
    logic signed [ERR_W-1:0]   err_reg,     err_next;
    logic signed [E5_W-1:0]    e5_reg,      e5_next;
    logic                      neg_reg,     neg_next;
    logic [MAG_W-1:0]          mag_reg,     mag_next;
    logic [PROD_W-1:0]         plo_reg,     plo_next;
    logic [PROD_W-1:0]         phi_reg,     phi_next;
    logic signed [E5_W-1:0]    r_reg,       r_next;
    logic signed [SUM_W-1:0]   vsum_reg,    vsum_next;
    logic                      phase_reg,   phase_next;

    logic [HI_W-1:0]           mul_a;
    logic [PROD_W-1:0]         prod;
    logic [MAG_W+DT_W-1:0]     scale_sum;
    logic [MAG_W-1:0]          r_mag;
    logic signed [SUM_W-1:0]   lim_s;
    logic                      vel_fix;
    logic                      pos_fix;
    logic [31:0]               vel_q;
    logic [15:0]               pos_q;

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign tx_valid = tx_valid_reg;
    assign tx_word  = tx_word_reg;

    // Shared multiplier: one half of the magnitude times the tick time.
    assign mul_a = (state_reg == ST_MUL_LO) ? HI_W'(mag_reg[LO_W-1:0])
                                            : mag_reg[MAG_W-1:LO_W];
    assign prod  = PROD_W'(mul_a * dt_reg);

    // Recombine the partial products and drop the Q0.16 fraction.
    assign scale_sum = {phi_reg, {LO_W{1'b0}}} + (MAG_W + DT_W)'(plo_reg);
    assign r_mag     = scale_sum[MAG_W+DT_W-1:DT_W];

    // Clamp limit in velocity format.
    assign lim_s = $signed(SUM_W'({speed_limit, {FRAC_BITS{1'b0}}}));

    // Truncate toward zero on the way out.
    assign vel_fix = actual_reg[VEL_W-1] && (actual_reg[FRAC_BITS-1:0] != '0);
    assign pos_fix = shaft_reg[POS_W-1] && (shaft_reg[FRAC_BITS-1:0] != '0);
    assign vel_q   = actual_reg[FRAC_BITS+31:FRAC_BITS] + 32'(vel_fix);
    assign pos_q   = shaft_reg[FRAC_BITS+15:FRAC_BITS] + 16'(pos_fix);

    // Sequence one command through the datapath.
    always_comb
    begin
        state_next    = state_reg;
        enabled_next  = enabled_reg;
        target_next   = target_reg;
        actual_next   = actual_reg;
        shaft_next    = shaft_reg;
        tx_valid_next = tx_valid_reg;
        tx_word_next  = tx_word_reg;
        dt_next       = dt_reg;
        err_next      = err_reg;
        e5_next       = e5_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        r_next        = r_reg;
        vsum_next     = vsum_reg;
        phase_next    = phase_reg;

        // Drop the output word once taken.
        if (tx_valid_reg && !tx_stall)
        begin
            tx_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (head_cmd.kind == CMD_CTRL)
                    begin
                        enabled_next = head_cmd.enable;
                        if (head_cmd.set_target)
                        begin
                            target_next = head_cmd.target;
                        end
                    end
                    else
                    begin
                        dt_next = head_cmd.dt;
                        if (enabled_reg)
                        begin
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            actual_next = '0;
                            state_next  = ST_EMIT;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                err_next   = (ERR_W'(target_reg) <<< FRAC_BITS) - ERR_W'(actual_reg);
                state_next = ST_ERR5;
            end
            ST_ERR5:
            begin
                e5_next    = (E5_W'(err_reg) <<< 2) + E5_W'(err_reg);
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                neg_next   = e5_reg[E5_W-1];
                mag_next   = e5_reg[E5_W-1] ? MAG_W'(-e5_reg) : MAG_W'(e5_reg);
                phase_next = 1'b0;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                plo_next   = prod;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                phi_next   = prod;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                r_next     = neg_reg ? -$signed(E5_W'(r_mag)) : $signed(E5_W'(r_mag));
                state_next = phase_reg ? ST_SUM_P : ST_SUM_V;
            end
            ST_SUM_V:
            begin
                vsum_next  = SUM_W'(actual_reg) + SUM_W'(r_reg);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (vsum_reg > lim_s)
                begin
                    actual_next = VEL_W'(lim_s);
                end
                else if (vsum_reg < -lim_s)
                begin
                    actual_next = VEL_W'(-lim_s);
                end
                else
                begin
                    actual_next = VEL_W'(vsum_reg);
                end
                state_next = ST_POS_MAG;
            end
            ST_POS_MAG:
            begin
                neg_next   = actual_reg[VEL_W-1];
                mag_next   = actual_reg[VEL_W-1] ? MAG_W'(-actual_reg) : MAG_W'(actual_reg);
                phase_next = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_SUM_P:
            begin
                shaft_next = shaft_reg + POS_W'(r_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!tx_valid_reg || !tx_stall)
                begin
                    tx_valid_next             = 1'b1;
                    tx_word_next.tx_id        = TPDO_BASE + 11'(node_id);
                    tx_word_next.drive_status = enabled_reg ? STATUS_ON : STATUS_OFF;
                    tx_word_next.velocity_out = $signed(vel_q);
                    tx_word_next.position_out = $signed(pos_q);
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, drive state and output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            enabled_reg  <= 1'b0;
            target_reg   <= '0;
            actual_reg   <= '0;
            shaft_reg    <= '0;
            tx_valid_reg <= 1'b0;
            tx_word_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            enabled_reg  <= enabled_next;
            target_reg   <= target_next;
            actual_reg   <= actual_next;
            shaft_reg    <= shaft_next;
            tx_valid_reg <= tx_valid_next;
            tx_word_reg  <= tx_word_next;
        end
    end

    // Working registers of the update sequence.
    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        err_reg   <= err_next;
        e5_reg    <= e5_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        r_reg     <= r_next;
        vsum_reg  <= vsum_next;
        phase_reg <= phase_next;
    end

endmodule

/* src/cvd_checker.sv */
// Port-level checker for the velocity drive model, bound to the top level.
`include "assert_macros.svh"

module cvd_checker
    import cvd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     tx_valid,
    input logic     tx_stall,
    input tx_word_t tx_word
);

    // Hold a stalled status word.
    `CVD_ASSERT_NEXT(a_tx_hold, clk, rst_n, tx_valid && tx_stall, tx_valid && $stable(tx_word), "stalled status word changed")

    // Report only the two status codes.
    `CVD_ASSERT_NOW(a_status_code, clk, rst_n, tx_valid, (tx_word.drive_status == STATUS_ON) || (tx_word.drive_status == STATUS_OFF), "unknown status word")

    // A disabled drive reports zero velocity.
    `CVD_ASSERT_NOW(a_off_stopped, clk, rst_n, tx_valid && (tx_word.drive_status == STATUS_OFF), tx_word.velocity_out == 0, "disabled drive reports motion")

    // Status frames always carry the transmit function code.
    `CVD_ASSERT_NOW(a_tx_fc, clk, rst_n, tx_valid, tx_word.tx_id[10:7] == TPDO_FC, "bad status frame identifier")

endmodule

bind canopen_velocity_drive_model_unit cvd_checker u_cvd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_word  (tx_word)
);
